// File: design/depth_pixel_backprojection_gate_unit_macros.svh
// assertion macros for the depth pixel back-projection gate
// no dependencies; taken in by files that check their own logic
`ifndef DEPTH_PIXEL_BACKPROJECTION_GATE_UNIT_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_GATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BPG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPG_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/bpg_pkg.sv
// types and constants of the depth pixel back-projection gate
// no dependencies; used by the top level, bpg_front, bpg_back and the testbench
package bpg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH_MM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH_MM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT_MM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT_MM = 3'd7;

  localparam logic [19:0] RST_INV_FOCAL_X   = 20'd27962;
  localparam logic [19:0] RST_INV_FOCAL_Y   = 20'd27962;
  localparam logic [15:0] RST_CENTER_X      = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y      = 16'd3840;
  localparam logic [15:0] RST_MIN_DEPTH_MM  = 16'd200;
  localparam logic [15:0] RST_MAX_DEPTH_MM  = 16'd5000;
  localparam logic [15:0] RST_MIN_HEIGHT_MM = 16'd50;
  localparam logic [15:0] RST_MAX_HEIGHT_MM = 16'd1500;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic        [15:0] forward_mm;
    logic signed [23:0] left_mm;
    logic signed [23:0] up_mm;
  } point_t;

  typedef struct packed {
    logic        [19:0] inv_focal_x;
    logic        [19:0] inv_focal_y;
    logic        [15:0] center_x;
    logic        [15:0] center_y;
    logic        [15:0] min_depth_mm;
    logic        [15:0] max_depth_mm;
    logic signed [15:0] min_height_mm;
    logic signed [15:0] max_height_mm;
  } cfg_t;

  // kept pixel, offsets from the principal point as sign and q4 magnitude
  typedef struct packed {
    logic [15:0] depth_mm;
    logic [15:0] mag_x;
    logic        neg_x;
    logic [15:0] mag_y;
    logic        neg_y;
  } work_t;

  // front to queue handoff
  typedef struct packed {
    logic  wr_en;
    logic  drop;
    work_t item;
  } front_out_t;

endpackage

// File: design/depth_pixel_backprojection_gate_unit.sv
// top level of the depth pixel back-projection gate
// depends on bpg_pkg, bpg_fifo, bpg_front, bpg_back and the assertion macro header
`include "depth_pixel_backprojection_gate_unit_macros.svh"

// Takes one depth pixel per clock and emits a 3-D point (forward, left, up, in
// millimetres) for each pixel that is on an even column and row, nonzero, inside
// the depth window and whose up value falls in the height window; all other
// pixels are absorbed without a result. Sustained rate is one item per clock as
// long as pop keeps up; each item goes through two registered multiplier stages
// (offset times depth, then times the reciprocal focal length) and one rounding
// and saturation stage; the height gate then picks what enters the result queue.
// The front gate feeds a small queue of MID_DEPTH items; the back end only starts
// an item when the result queue of OUT_DEPTH items has a slot reserved for it, so
// full rate needs OUT_DEPTH of at least five. Configuration is to be written
// through cfg_wr_en / cfg_index / cfg_data while idle; the block does not check.
module depth_pixel_backprojection_gate_unit #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel side
  input  logic                                  push,
  output logic                                  full,
  input  bpg_pkg::pixel_t                       pixel,
  // point side
  output logic                                  empty,
  input  logic                                  pop,
  output bpg_pkg::point_t                       point,
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [bpg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpg_pkg::CFG_DATA_W-1:0]        cfg_data
);

  bpg_pkg::cfg_t       cfg;
  bpg_pkg::front_out_t front;
  bpg_pkg::work_t      mid_head;
  bpg_pkg::point_t     res;
  logic                mid_full;
  logic                mid_empty;
  logic                mid_rd;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic                res_valid;
  logic                out_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_focal_x   <= bpg_pkg::RST_INV_FOCAL_X;
      cfg.inv_focal_y   <= bpg_pkg::RST_INV_FOCAL_Y;
      cfg.center_x      <= bpg_pkg::RST_CENTER_X;
      cfg.center_y      <= bpg_pkg::RST_CENTER_Y;
      cfg.min_depth_mm  <= bpg_pkg::RST_MIN_DEPTH_MM;
      cfg.max_depth_mm  <= bpg_pkg::RST_MAX_DEPTH_MM;
      cfg.min_height_mm <= bpg_pkg::RST_MIN_HEIGHT_MM;
      cfg.max_height_mm <= bpg_pkg::RST_MAX_HEIGHT_MM;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bpg_pkg::REG_INV_FOCAL_X:   cfg.inv_focal_x   <= cfg_data;
        bpg_pkg::REG_INV_FOCAL_Y:   cfg.inv_focal_y   <= cfg_data;
        bpg_pkg::REG_CENTER_X:      cfg.center_x      <= cfg_data[15:0];
        bpg_pkg::REG_CENTER_Y:      cfg.center_y      <= cfg_data[15:0];
        bpg_pkg::REG_MIN_DEPTH_MM:  cfg.min_depth_mm  <= cfg_data[15:0];
        bpg_pkg::REG_MAX_DEPTH_MM:  cfg.max_depth_mm  <= cfg_data[15:0];
        bpg_pkg::REG_MIN_HEIGHT_MM: cfg.min_height_mm <= cfg_data[15:0];
        bpg_pkg::REG_MAX_HEIGHT_MM: cfg.max_height_mm <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // a pixel is taken whenever the middle queue has room, even if it is dropped
  assign full = mid_full;

  bpg_front u_front (
    .pixel (pixel),
    .take  (push && !mid_full),
    .cfg   (cfg),
    .front (front)
  );

  // middle queue decouples gating from the arithmetic pipeline
  bpg_fifo #(
    .WIDTH ($bits(bpg_pkg::work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front.wr_en),
    .wr_data (front.item),
    .rd_en   (mid_rd),
    .rd_data (mid_head),
    .empty   (mid_empty),
    .full    (mid_full),
    .count   (mid_count)
  );

  bpg_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src       (mid_head),
    .src_empty (mid_empty),
    .src_pop   (mid_rd),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue, space reserved by the back end before it issues
  bpg_fifo #(
    .WIDTH ($bits(bpg_pkg::point_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (point),
    .empty   (empty),
    .full    (out_full),
    .count   (out_count)
  );

  // the credit scheme must never let a finished point hit a full queue
  `BPG_ASSERT_IMP(a_out_room, clk, rst, res_valid, !out_full)
  // the back end only pulls from the middle queue when it holds an item
  `BPG_ASSERT_IMP(a_mid_read_ok, clk, rst, mid_rd, !mid_empty)
  // a dropped pixel never grows the middle queue
  `BPG_ASSERT_NXT(a_drop_no_grow, clk, rst, front.drop, mid_count <= $past(mid_count))

endmodule

// File: design/bpg_fifo.sv
// small generic queue with registered storage and show-ahead head
// no dependencies
module bpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == CW'(0));
  assign full    = (count == CW'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/bpg_front.sv
// front end: parity, zero and depth window gating, q4 offsets from the center
// depends on bpg_pkg
module bpg_front (
  input  bpg_pkg::pixel_t     pixel,
  input  logic                take,
  input  bpg_pkg::cfg_t       cfg,
  output bpg_pkg::front_out_t front
);

  logic        keep;
  logic [16:0] dx;
  logic [16:0] dy;

  always_comb begin
    keep = !pixel.pixel_col[0] && !pixel.pixel_row[0]
        && (pixel.depth_mm != 16'd0)
        && (pixel.depth_mm >= cfg.min_depth_mm)
        && (pixel.depth_mm <= cfg.max_depth_mm);
    dx = {1'b0, pixel.pixel_col, 4'b0000} - {1'b0, cfg.center_x};
    dy = {1'b0, pixel.pixel_row, 4'b0000} - {1'b0, cfg.center_y};

    front.item.depth_mm = pixel.depth_mm;
    // positive offset means the point lies to the right / below, so negative result
    front.item.neg_x = !dx[16] && (dx != 17'd0);
    front.item.neg_y = !dy[16] && (dy != 17'd0);
    front.item.mag_x = dx[16] ? 16'(-dx) : dx[15:0];
    front.item.mag_y = dy[16] ? 16'(-dy) : dy[15:0];
    front.wr_en = take && keep;
    front.drop  = take && !keep;
  end

endmodule

// File: design/bpg_back.sv
// back end: two multiplier stages, rounding and saturation, height gate
// depends on bpg_pkg; issues only when the result queue has room reserved
module bpg_back #(
  parameter int OUT_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpg_pkg::cfg_t                       cfg,
  input  bpg_pkg::work_t                      src,
  input  logic                                src_empty,
  output logic                                src_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
  output logic                                res_valid,
  output bpg_pkg::point_t                     res
);

  localparam int CW = $clog2(OUT_DEPTH + 1) + 2;

  logic        v1, v2, v3;
  logic [15:0] z1, z2;
  logic        nx1, ny1, nx2, ny2;
  logic [31:0] px1, py1;
  logic [51:0] qx2, qy2;
  bpg_pkg::point_t pt3;
  logic [CW-1:0]   occupied;
  logic [52:0]     sum_x, sum_y;
  logic signed [23:0] lo_h, hi_h;

  function automatic logic [23:0] sat24(input logic [24:0] r, input logic neg);
    logic [23:0] o;
    if (neg) begin
      if (r >= 25'h0800000) begin
        o = 24'h800000;
      end else begin
        o = 24'(~r + 25'd1);
      end
    end else if (r > 25'h07FFFFF) begin
      o = 24'h7FFFFF;
    end else begin
      o = r[23:0];
    end
    return o;
  endfunction

  // items in flight plus items waiting in the result queue
  assign occupied = CW'(out_count) + CW'(v1) + CW'(v2) + CW'(v3);
  assign src_pop  = !src_empty && (occupied < CW'(OUT_DEPTH));

  assign sum_x = {1'b0, qx2} + (53'd1 << 27);
  assign sum_y = {1'b0, qy2} + (53'd1 << 27);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= src_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    z1  <= src.depth_mm;
    nx1 <= src.neg_x;
    ny1 <= src.neg_y;
    px1 <= 32'(src.mag_x) * 32'(src.depth_mm);
    py1 <= 32'(src.mag_y) * 32'(src.depth_mm);
    z2  <= z1;
    nx2 <= nx1;
    ny2 <= ny1;
    qx2 <= 52'(px1) * 52'(cfg.inv_focal_x);
    qy2 <= 52'(py1) * 52'(cfg.inv_focal_y);
    pt3.forward_mm <= z2;
    pt3.left_mm    <= sat24(sum_x[52:28], nx2);
    pt3.up_mm      <= sat24(sum_y[52:28], ny2);
  end

  assign lo_h      = 24'(cfg.min_height_mm);
  assign hi_h      = 24'(cfg.max_height_mm);
  assign res       = pt3;
  assign res_valid = v3 && (pt3.up_mm >= lo_h) && (pt3.up_mm <= hi_h);

endmodule

// File: verif/depth_pixel_backprojection_gate_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for depth_pixel_backprojection_gate_unit
// needs bpg_pkg and the block's rtl; directed table, pressure run, random phases

module depth_pixel_backprojection_gate_unit_tb;

  localparam int          SETTLE_CYCLES = 16;     // drain wait that lets dropped pixels flush out
  localparam int          HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int          PRESS_ITEMS   = 80;
  localparam int          RANDOM_ITEMS  = 410;    // per random phase
  localparam int          MAX_PRINTED   = 40;
  localparam int unsigned TIMEOUT_NS    = 10_000_000;

  // how the expected outcome of a directed row is found
  typedef enum logic [1:0] {CHK_MODEL, CHK_DROP, CHK_POINT} check_t;
  typedef enum logic       {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [bpg_pkg::CFG_IDX_W-1:0]  idx;
    logic [bpg_pkg::CFG_DATA_W-1:0] data;
    bpg_pkg::pixel_t                px;
    check_t                         chk;
    bpg_pkg::point_t                want;
  } dir_row_t;

  logic                           clk;
  logic                           rst;
  logic                           push;
  logic                           full;
  bpg_pkg::pixel_t                pixel;
  logic                           empty;
  logic                           pop;
  bpg_pkg::point_t                point;
  logic                           cfg_wr_en;
  logic [bpg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpg_pkg::CFG_DATA_W-1:0] cfg_data;

  bpg_pkg::cfg_t   cfg_now;          // register values as the block should hold them
  bpg_pkg::point_t pending_points[$];
  dir_row_t        dir_rows[$];
  int              mismatch_count = 0;
  int              idle_pct = 0;     // chance per cycle that the sender stays idle
  int              stall_pct = 0;    // chance per cycle that the receiver holds pop low
  bit              hold_req = 1'b0;  // asks the receiver for one long hold-off

  depth_pixel_backprojection_gate_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .point     (point),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // one axis of the pinhole back-projection: -(pix - ctr/16) * z * inv / 2^24
  // offset is exact in q4, the product exact in q28 mm; round half away from zero,
  // apply the sign, then clamp to 24-bit signed
  function automatic logic signed [23:0] backproject_axis(input logic [11:0] pix,
                                                          input logic [15:0] ctr,
                                                          input logic [15:0] z,
                                                          input logic [19:0] inv);
    longint          off;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned r;
    off  = longint'({pix, 4'd0}) - longint'(ctr);
    mag  = (off < 0) ? -off : off;
    prod = mag * z * inv;
    r    = (prod + (64'd1 << 27)) >> 28;
    // pixel right of or below the center gives a negative result
    if (off > 0) begin
      return (r >= 64'd8388608) ? 24'h800000 : 24'(-r);
    end
    return (r > 64'd8388607) ? 24'h7FFFFF : 24'(r);
  endfunction

  // point the block should emit for a pixel; returns 0 when the pixel is dropped
  function automatic logic project_pixel(input bpg_pkg::pixel_t p,
                                         output bpg_pkg::point_t pt);
    logic signed [23:0] up;
    pt = '0;
    // only even columns and rows, nonzero depth inside the inclusive depth window
    if (p.pixel_col[0] || p.pixel_row[0] || p.depth_mm == 16'd0) return 1'b0;
    if (p.depth_mm < cfg_now.min_depth_mm || p.depth_mm > cfg_now.max_depth_mm) return 1'b0;
    up = backproject_axis(p.pixel_row, cfg_now.center_y, p.depth_mm, cfg_now.inv_focal_y);
    // height gate on the saturated value, bounds inclusive
    if (up < $signed(cfg_now.min_height_mm) || up > $signed(cfg_now.max_height_mm)) begin
      return 1'b0;
    end
    pt.forward_mm = p.depth_mm;
    pt.left_mm    = backproject_axis(p.pixel_col, cfg_now.center_x, p.depth_mm,
                                     cfg_now.inv_focal_x);
    pt.up_mm      = up;
    return 1'b1;
  endfunction

  // register write; bits above a register's width are dropped by the block
  task automatic write_reg(input logic [bpg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpg_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      bpg_pkg::REG_INV_FOCAL_X:   cfg_now.inv_focal_x   = val[19:0];
      bpg_pkg::REG_INV_FOCAL_Y:   cfg_now.inv_focal_y   = val[19:0];
      bpg_pkg::REG_CENTER_X:      cfg_now.center_x      = val[15:0];
      bpg_pkg::REG_CENTER_Y:      cfg_now.center_y      = val[15:0];
      bpg_pkg::REG_MIN_DEPTH_MM:  cfg_now.min_depth_mm  = val[15:0];
      bpg_pkg::REG_MAX_DEPTH_MM:  cfg_now.max_depth_mm  = val[15:0];
      bpg_pkg::REG_MIN_HEIGHT_MM: cfg_now.min_height_mm = val[15:0];
      bpg_pkg::REG_MAX_HEIGHT_MM: cfg_now.max_height_mm = val[15:0];
      default: ;
    endcase
  endtask

  // stop sending, wait for every expected point, then let dropped pixels flush out
  task automatic drain_points();
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // offer one item until the block takes it; called at a rising edge
  task automatic send_pixel(input bpg_pkg::pixel_t p, input check_t chk,
                            input bpg_pkg::point_t want);
    bpg_pkg::point_t pt;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (full);
    case (chk)
      CHK_MODEL: if (project_pixel(p, pt)) pending_points.insert(pending_points.size(), pt);
      CHK_POINT: pending_points.insert(pending_points.size(), want);
      default: ;
    endcase
  endtask

  // mostly well-formed pixels (even position, depth in a useful part of the window),
  // the rest raw noise over every bit
  function automatic bpg_pkg::pixel_t random_pixel();
    bpg_pkg::pixel_t p;
    int              lo;
    int              hi;
    p.depth_mm  = 16'($urandom);
    p.pixel_col = 12'($urandom);
    p.pixel_row = 12'($urandom);
    if ($urandom_range(3) != 0) begin
      lo = (cfg_now.min_depth_mm == 16'd0) ? 1 : int'(cfg_now.min_depth_mm);
      hi = int'(cfg_now.max_depth_mm);
      // shallow depths keep the up value inside the height window more often
      if (lo + 3000 < hi && $urandom_range(3) != 0) hi = lo + 3000;
      if (lo <= hi) p.depth_mm = 16'($urandom_range(lo, hi));
      p.pixel_col[0] = 1'b0;
      p.pixel_row[0] = 1'b0;
    end
    return p;
  endfunction

  task automatic add_px(input logic [15:0] z, input logic [11:0] col, input logic [11:0] row,
                        input check_t chk, input bpg_pkg::point_t want);
    dir_row_t r;
    r.kind = ROW_PIXEL;
    r.idx  = '0;
    r.data = '0;
    r.px   = {z, col, row};
    r.chk  = chk;
    r.want = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_cfg(input logic [bpg_pkg::CFG_IDX_W-1:0] idx,
                         input logic [bpg_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = val;
    r.px   = '0;
    r.chk  = CHK_DROP;
    r.want = '0;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // result side: pop at random, or hold off for a long stretch when asked
  initial begin : result_side
    int held;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each accepted point with the oldest expectation, field by field
  always @(posedge clk) begin : check_points
    bpg_pkg::point_t want;
    if (!rst && pop && !empty) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point fwd %0d left %0d up %0d",
                                  point.forward_mm, point.left_mm, point.up_mm));
      end else begin
        want = pending_points.pop_front();
        if (point.forward_mm !== want.forward_mm) begin
          report_mismatch($sformatf("forward_mm got %0d want %0d",
                                    point.forward_mm, want.forward_mm));
        end
        if (point.left_mm !== want.left_mm) begin
          report_mismatch($sformatf("left_mm got %0d want %0d", point.left_mm, want.left_mm));
        end
        if (point.up_mm !== want.up_mm) begin
          report_mismatch($sformatf("up_mm got %0d want %0d", point.up_mm, want.up_mm));
        end
      end
    end
  end

  initial begin : stimulus
    int              ph;
    int              lo_depth;
    int              phase_idle[4]  = '{0, 56, 0, 22};
    int              phase_stall[4] = '{0, 0, 56, 22};
    bpg_pkg::pixel_t p;

    rst       <= 1'b1;
    push      <= 1'b0;
    pixel     <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    cfg_now.inv_focal_x   = bpg_pkg::RST_INV_FOCAL_X;
    cfg_now.inv_focal_y   = bpg_pkg::RST_INV_FOCAL_Y;
    cfg_now.center_x      = bpg_pkg::RST_CENTER_X;
    cfg_now.center_y      = bpg_pkg::RST_CENTER_Y;
    cfg_now.min_depth_mm  = bpg_pkg::RST_MIN_DEPTH_MM;
    cfg_now.max_depth_mm  = bpg_pkg::RST_MAX_DEPTH_MM;
    cfg_now.min_height_mm = bpg_pkg::RST_MIN_HEIGHT_MM;
    cfg_now.max_height_mm = bpg_pkg::RST_MAX_HEIGHT_MM;

    // directed table, reset settings first: center at column 320, row 240
    // at the principal point up is zero, under the default height floor
    add_px(16'd1000, 12'd320, 12'd240, CHK_DROP, '0);
    add_px(16'd1000, 12'd321, 12'd100, CHK_DROP, '0);    // odd column
    add_px(16'd1000, 12'd320, 12'd101, CHK_DROP, '0);    // odd row
    add_px(16'd0, 12'd320, 12'd100, CHK_DROP, '0);       // zero depth
    add_px(16'd199, 12'd320, 12'd100, CHK_DROP, '0);     // just under the depth window
    add_px(16'd5001, 12'd320, 12'd100, CHK_DROP, '0);    // just over the depth window
    add_px(16'd200, 12'd320, 12'd100, CHK_MODEL, '0);    // depth bounds are inclusive
    add_px(16'd5000, 12'd320, 12'd100, CHK_MODEL, '0);
    add_px(16'd2000, 12'd0, 12'd0, CHK_MODEL, '0);
    add_px(16'd2000, 12'd4094, 12'd4094, CHK_MODEL, '0);
    add_px(16'd65535, 12'd4095, 12'd4095, CHK_DROP, '0); // all ones, odd position
    // widest windows; upper data bits above 16 must be ignored
    add_cfg(bpg_pkg::REG_MIN_DEPTH_MM, 20'h00001);
    add_cfg(bpg_pkg::REG_MAX_DEPTH_MM, 20'hFFFFF);
    add_cfg(bpg_pkg::REG_MIN_HEIGHT_MM, 20'hF8000);
    add_cfg(bpg_pkg::REG_MAX_HEIGHT_MM, 20'h07FFF);
    add_px(16'd65535, 12'd320, 12'd240, CHK_POINT, '{16'd65535, 24'h0, 24'h0});
    add_px(16'd1, 12'd320, 12'd240, CHK_POINT, '{16'd1, 24'h0, 24'h0});
    // largest reciprocal saturates left, zero reciprocal gives up of zero
    add_cfg(bpg_pkg::REG_INV_FOCAL_X, 20'hFFFFF);
    add_cfg(bpg_pkg::REG_INV_FOCAL_Y, 20'h00000);
    add_cfg(bpg_pkg::REG_CENTER_X, 20'h00000);
    add_px(16'd65535, 12'd4094, 12'd2, CHK_POINT, '{16'd65535, 24'h800000, 24'h0});
    add_cfg(bpg_pkg::REG_CENTER_X, 20'h0FFFF);
    add_cfg(bpg_pkg::REG_CENTER_Y, 20'hFFFFF);
    add_px(16'd65535, 12'd0, 12'd0, CHK_POINT, '{16'd65535, 24'h7FFFFF, 24'h0});
    // offset of 16 pixels times 512 mm times 1024 lands exactly on one half
    add_cfg(bpg_pkg::REG_INV_FOCAL_X, 20'd1024);
    add_cfg(bpg_pkg::REG_CENTER_X, 20'd5120);
    add_px(16'd512, 12'd304, 12'd2, CHK_POINT, '{16'd512, 24'h000001, 24'h0});
    add_px(16'd512, 12'd336, 12'd2, CHK_POINT, '{16'd512, 24'hFFFFFF, 24'h0});
    // inverted depth window rejects everything
    add_cfg(bpg_pkg::REG_MIN_DEPTH_MM, 20'd100);
    add_cfg(bpg_pkg::REG_MAX_DEPTH_MM, 20'd99);
    add_px(16'd100, 12'd320, 12'd240, CHK_DROP, '0);
    // inverted height window rejects everything
    add_cfg(bpg_pkg::REG_MIN_DEPTH_MM, 20'd1);
    add_cfg(bpg_pkg::REG_MAX_DEPTH_MM, 20'hFFFF);
    add_cfg(bpg_pkg::REG_MIN_HEIGHT_MM, 20'd10);
    add_cfg(bpg_pkg::REG_MAX_HEIGHT_MM, 20'hFFFF6);
    add_px(16'd1000, 12'd320, 12'd240, CHK_DROP, '0);
    // single-value height window
    add_cfg(bpg_pkg::REG_MIN_HEIGHT_MM, 20'd0);
    add_cfg(bpg_pkg::REG_MAX_HEIGHT_MM, 20'd0);
    add_cfg(bpg_pkg::REG_INV_FOCAL_Y, bpg_pkg::RST_INV_FOCAL_Y);
    add_cfg(bpg_pkg::REG_CENTER_Y, 20'(bpg_pkg::RST_CENTER_Y));
    add_px(16'd1000, 12'd320, 12'd240, CHK_POINT, '{16'd1000, 24'h0, 24'h0});
    add_px(16'd3000, 12'd0, 12'd4094, CHK_MODEL, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_points();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].chk, dir_rows[i].want);
      end
    end

    // pressure: every item makes a point while the receiver holds off,
    // so the queues fill and full must push back on the sender
    drain_points();
    write_reg(bpg_pkg::REG_INV_FOCAL_X, bpg_pkg::RST_INV_FOCAL_X);
    write_reg(bpg_pkg::REG_INV_FOCAL_Y, bpg_pkg::RST_INV_FOCAL_Y);
    write_reg(bpg_pkg::REG_CENTER_X, 20'(bpg_pkg::RST_CENTER_X));
    write_reg(bpg_pkg::REG_CENTER_Y, 20'(bpg_pkg::RST_CENTER_Y));
    write_reg(bpg_pkg::REG_MIN_DEPTH_MM, 20'd1);
    write_reg(bpg_pkg::REG_MAX_DEPTH_MM, 20'hFFFF);
    write_reg(bpg_pkg::REG_MIN_HEIGHT_MM, 20'h08000);
    write_reg(bpg_pkg::REG_MAX_HEIGHT_MM, 20'h07FFF);
    hold_req = 1'b1;
    repeat (PRESS_ITEMS) begin
      // shallow depth keeps up well inside the height window
      p.depth_mm  = 16'($urandom_range(1, 4000));
      p.pixel_col = {11'($urandom), 1'b0};
      p.pixel_row = {11'($urandom), 1'b0};
      send_pixel(p, CHK_MODEL, '0);
    end

    // random phases, fresh settings and a different idling mix in each
    for (ph = 0; ph < 4; ph++) begin
      drain_points();
      lo_depth = $urandom_range(0, 1500);
      write_reg(bpg_pkg::REG_INV_FOCAL_X, 20'($urandom_range(2000, 60000)));
      write_reg(bpg_pkg::REG_INV_FOCAL_Y, 20'($urandom_range(2000, 60000)));
      write_reg(bpg_pkg::REG_CENTER_X, {4'($urandom), 16'($urandom)});
      write_reg(bpg_pkg::REG_CENTER_Y, {4'($urandom), 16'($urandom)});
      write_reg(bpg_pkg::REG_MIN_DEPTH_MM, {4'($urandom), 16'(lo_depth)});
      write_reg(bpg_pkg::REG_MAX_DEPTH_MM,
                {4'($urandom), 16'($urandom_range(lo_depth + 500, 65535))});
      write_reg(bpg_pkg::REG_MIN_HEIGHT_MM,
                {4'($urandom), 16'(-int'($urandom_range(0, 32768)))});
      write_reg(bpg_pkg::REG_MAX_HEIGHT_MM, {4'($urandom), 16'($urandom_range(0, 32767))});
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (RANDOM_ITEMS) send_pixel(random_pixel(), CHK_MODEL, '0);
    end

    drain_points();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/bpg_pkg.sv
design/bpg_fifo.sv
design/bpg_front.sv
design/bpg_back.sv
design/depth_pixel_backprojection_gate_unit.sv
verif/depth_pixel_backprojection_gate_unit_tb.sv
